[rtl/core/ats_pkg.sv]
`default_nettype none

package ats_pkg;

  // Default counter widths
  localparam int ROW_BITS_DEF    = 16;
  localparam int COL_BITS_DEF    = 12;
  localparam int OFFSET_BITS_DEF = 20;
  localparam int LEN_BITS_DEF    = 8;

  // Token kinds as seen on the result channel
  typedef enum logic [2:0] {
    KIND_IDENT  = 3'd0,
    KIND_NUMBER = 3'd1,
    KIND_COLON  = 3'd2,
    KIND_COMMA  = 3'd3,
    KIND_EOL    = 3'd4,
    KIND_EOF    = 3'd5,
    KIND_STRAY  = 3'd6
  } kind_t;

  // Scanner modes
  typedef enum logic [2:0] {
    MODE_IDLE    = 3'd0,
    MODE_IDENT   = 3'd1,
    MODE_NUMBER  = 3'd2,
    MODE_COMMENT = 3'd3,
    MODE_DONE    = 3'd4
  } mode_t;

  // Special bytes
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_UNDER = 8'h5F;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_COMMA = 8'h2C;

  function automatic logic is_letter(input logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  // Space, tab, LF, VT, FF, CR
  function automatic logic is_space(input logic [7:0] c);
    return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
  endfunction

  function automatic logic is_word(input logic [7:0] c);
    return is_letter(c) || is_digit(c) || c == CH_UNDER || c == CH_DOT;
  endfunction

endpackage

`default_nettype wire

[rtl/core/ats_core.sv]
`default_nettype none

// Scanner state and the per-byte step; up to two results per request
module ats_core #(
  parameter int ROW_BITS    = ats_pkg::ROW_BITS_DEF,
  parameter int COL_BITS    = ats_pkg::COL_BITS_DEF,
  parameter int OFFSET_BITS = ats_pkg::OFFSET_BITS_DEF,
  parameter int LEN_BITS    = ats_pkg::LEN_BITS_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   take,
  input  wire logic [7:0]             ch,
  input  wire logic                   is_end,
  output ats_pkg::kind_t              res_kind  [2],
  output logic [ROW_BITS-1:0]         res_row   [2],
  output logic [COL_BITS-1:0]         res_col   [2],
  output logic [OFFSET_BITS-1:0]      res_off   [2],
  output logic [LEN_BITS-1:0]         res_len   [2],
  output logic [7:0]                  res_stray [2],
  output logic [1:0]                  res_cnt
);

  ats_pkg::mode_t           mode, mode_next;
  logic [ROW_BITS-1:0]      row_count, row_count_next;
  logic [COL_BITS-1:0]      col_count, col_count_next;
  logic                     prev_nl, prev_nl_next;
  logic [OFFSET_BITS-1:0]   byte_offset, byte_offset_next;
  logic [ROW_BITS-1:0]      tok_row, tok_row_next;
  logic [COL_BITS-1:0]      tok_col, tok_col_next;
  logic [OFFSET_BITS-1:0]   tok_offset, tok_offset_next;
  logic [LEN_BITS-1:0]      tok_length, tok_length_next;
  logic                     prev_ended, prev_ended_next;
  logic                     any_seen, any_seen_next;

  // Next state and results for the byte on the input
  always_comb begin
    logic                   endf;
    logic                   go;
    logic                   pe;
    logic                   idx;
    logic [ROW_BITS-1:0]    rown;
    logic [COL_BITS-1:0]    coln;
    logic [OFFSET_BITS-1:0] here;
    ats_pkg::kind_t         pend_kind;

    mode_next        = mode;
    row_count_next   = row_count;
    col_count_next   = col_count;
    prev_nl_next     = prev_nl;
    byte_offset_next = byte_offset;
    tok_row_next     = tok_row;
    tok_col_next     = tok_col;
    tok_offset_next  = tok_offset;
    tok_length_next  = tok_length;
    prev_ended_next  = prev_ended;
    any_seen_next    = any_seen;
    res_cnt          = 2'd0;
    for (int i = 0; i < 2; i++) begin
      res_kind[i]  = ats_pkg::KIND_IDENT;
      res_row[i]   = '0;
      res_col[i]   = '0;
      res_off[i]   = '0;
      res_len[i]   = '0;
      res_stray[i] = '0;
    end

    endf      = is_end || (ch == ats_pkg::CH_NUL);
    go        = 1'b0;
    pe        = prev_ended;
    idx       = 1'b0;
    pend_kind = (mode == ats_pkg::MODE_NUMBER) ? ats_pkg::KIND_NUMBER : ats_pkg::KIND_IDENT;
    rown      = prev_nl ? ((row_count == {ROW_BITS{1'b1}}) ? row_count
                                                           : row_count + ROW_BITS'(1))
                        : row_count;
    coln      = prev_nl ? COL_BITS'(1)
                        : ((col_count == {COL_BITS{1'b1}}) ? col_count
                                                           : col_count + COL_BITS'(1));
    here      = byte_offset;

    if (mode == ats_pkg::MODE_DONE) begin
      // stopped until reset
    end else if (endf) begin
      // flush a pending word, then end of file if anything was seen
      if (mode == ats_pkg::MODE_IDENT || mode == ats_pkg::MODE_NUMBER) begin
        res_kind[0] = pend_kind;
        res_row[0]  = tok_row;
        res_col[0]  = tok_col;
        res_off[0]  = tok_offset;
        res_len[0]  = tok_length;
        res_cnt     = 2'd1;
        idx         = 1'b1;
        any_seen_next = 1'b1;
      end
      if (any_seen_next) begin
        res_kind[idx] = ats_pkg::KIND_EOF;
        res_row[idx]  = row_count;
        res_col[idx]  = col_count;
        res_off[idx]  = byte_offset;
        res_len[idx]  = '0;
        res_cnt       = res_cnt + 2'd1;
      end
      mode_next       = ats_pkg::MODE_DONE;
      prev_ended_next = 1'b0;
    end else begin
      // position bookkeeping for a data byte
      row_count_next   = rown;
      col_count_next   = coln;
      prev_nl_next     = (ch == ats_pkg::CH_LF);
      byte_offset_next = (byte_offset == {OFFSET_BITS{1'b1}}) ? byte_offset
                                                              : byte_offset + OFFSET_BITS'(1);

      if (mode == ats_pkg::MODE_COMMENT) begin
        if (ch == ats_pkg::CH_LF) begin
          mode_next = ats_pkg::MODE_IDLE;
        end
      end else begin
        go = 1'b1;
        // extend or close a word in progress
        if ((mode == ats_pkg::MODE_IDENT && ats_pkg::is_word(ch)) ||
            (mode == ats_pkg::MODE_NUMBER && ats_pkg::is_digit(ch))) begin
          tok_length_next = (tok_length == {LEN_BITS{1'b1}}) ? tok_length
                                                             : tok_length + LEN_BITS'(1);
          go = 1'b0;
        end else if (mode == ats_pkg::MODE_IDENT || mode == ats_pkg::MODE_NUMBER) begin
          res_kind[0]   = pend_kind;
          res_row[0]    = tok_row;
          res_col[0]    = tok_col;
          res_off[0]    = tok_offset;
          res_len[0]    = tok_length;
          res_cnt       = 2'd1;
          idx           = 1'b1;
          any_seen_next = 1'b1;
          pe            = 1'b1;
          mode_next     = ats_pkg::MODE_IDLE;
        end

        // classify the byte itself
        if (go) begin
          if (ch == ats_pkg::CH_LF) begin
            if (pe) begin
              res_kind[idx] = ats_pkg::KIND_EOL;
              res_row[idx]  = rown;
              res_col[idx]  = coln;
              res_off[idx]  = here;
              res_len[idx]  = LEN_BITS'(1);
              res_cnt       = res_cnt + 2'd1;
            end
            pe = 1'b0;
          end else if (ats_pkg::is_space(ch)) begin
            pe = 1'b0;
          end else if (ch == ats_pkg::CH_SEMI) begin
            mode_next = ats_pkg::MODE_COMMENT;
            pe        = 1'b0;
          end else if (ats_pkg::is_word(ch)) begin
            mode_next       = ats_pkg::is_digit(ch) ? ats_pkg::MODE_NUMBER
                                                    : ats_pkg::MODE_IDENT;
            tok_row_next    = rown;
            tok_col_next    = coln;
            tok_offset_next = here;
            tok_length_next = LEN_BITS'(1);
            pe              = 1'b0;
          end else if (ch == ats_pkg::CH_COLON || ch == ats_pkg::CH_COMMA) begin
            res_kind[idx] = (ch == ats_pkg::CH_COLON) ? ats_pkg::KIND_COLON
                                                      : ats_pkg::KIND_COMMA;
            res_row[idx]  = rown;
            res_col[idx]  = coln;
            res_off[idx]  = here;
            res_len[idx]  = LEN_BITS'(1);
            res_cnt       = res_cnt + 2'd1;
            any_seen_next = 1'b1;
            pe            = 1'b1;
          end else begin
            res_kind[idx]  = ats_pkg::KIND_STRAY;
            res_row[idx]   = rown;
            res_col[idx]   = coln;
            res_off[idx]   = here;
            res_len[idx]   = LEN_BITS'(1);
            res_stray[idx] = ch;
            res_cnt        = res_cnt + 2'd1;
            mode_next      = ats_pkg::MODE_DONE;
            pe             = 1'b0;
          end
        end
        prev_ended_next = pe;
      end
    end
  end

  // State registers, advanced once per accepted request
  always_ff @(posedge clk) begin
    if (rst) begin
      mode        <= ats_pkg::MODE_IDLE;
      row_count   <= ROW_BITS'(1);
      col_count   <= '0;
      prev_nl     <= 1'b0;
      byte_offset <= '0;
      tok_row     <= '0;
      tok_col     <= '0;
      tok_offset  <= '0;
      tok_length  <= '0;
      prev_ended  <= 1'b0;
      any_seen    <= 1'b0;
    end else if (take) begin
      mode        <= mode_next;
      row_count   <= row_count_next;
      col_count   <= col_count_next;
      prev_nl     <= prev_nl_next;
      byte_offset <= byte_offset_next;
      tok_row     <= tok_row_next;
      tok_col     <= tok_col_next;
      tok_offset  <= tok_offset_next;
      tok_length  <= tok_length_next;
      prev_ended  <= prev_ended_next;
      any_seen    <= any_seen_next;
    end
  end

`ifndef NO_ASSERTIONS
  // once stopped, the scanner stays stopped
  a_done_sticky: assert property (@(posedge clk) disable iff (rst)
    mode == ats_pkg::MODE_DONE |=> mode == ats_pkg::MODE_DONE)
    else $error("scanner left the stopped mode");

  // a stopped scanner produces nothing
  a_done_silent: assert property (@(posedge clk) disable iff (rst)
    mode == ats_pkg::MODE_DONE |-> res_cnt == 2'd0)
    else $error("results from a stopped scanner");

  // the row never drops below one
  a_row_nonzero: assert property (@(posedge clk) disable iff (rst)
    row_count != '0)
    else $error("row counter reached zero");
`endif

endmodule

`default_nettype wire

[rtl/core/assembly_token_scanner.sv]
`default_nettype none

// Assembly token scanner.
// Input channel (in_valid/in_ready): one source byte per request in ch; is_end,
// or a zero byte, marks end of data. Output channel (out_valid/out_ready): one
// token descriptor per request with kind, start row/column/offset, length,
// stray_byte and last, which flags the final result caused by one input byte.
// A byte causes zero, one or two results. Results are registered in the queue
// before they appear on the output. Throughput is one byte per cycle while the
// receiver keeps up; a byte that closes a word and is itself a token gives two
// results, and these leave the output one after the other.
// Results sit in a four-entry queue; in_ready is high while at least two
// entries are free, so a stalled receiver stops input once three or more
// results wait, and no result is lost. Rate is set by the queue drain.
// After end of data or a stray byte the scanner gives nothing until reset.
// Reset (rst, synchronous) empties the queue and returns the scanner to row 1,
// column 0, offset 0 with no token seen.
module assembly_token_scanner #(
  parameter int ROW_BITS    = ats_pkg::ROW_BITS_DEF,
  parameter int COL_BITS    = ats_pkg::COL_BITS_DEF,
  parameter int OFFSET_BITS = ats_pkg::OFFSET_BITS_DEF,
  parameter int LEN_BITS    = ats_pkg::LEN_BITS_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire logic [7:0]             ch,
  input  wire logic                   is_end,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output logic [2:0]                  kind,
  output logic [ROW_BITS-1:0]         start_row,
  output logic [COL_BITS-1:0]         start_col,
  output logic [OFFSET_BITS-1:0]      start_offset,
  output logic [LEN_BITS-1:0]         length,
  output logic [7:0]                  stray_byte,
  output logic                        last
);

  localparam int QDEPTH = 4;
  localparam int PTR_W  = $clog2(QDEPTH);
  localparam int CNT_W  = $clog2(QDEPTH + 1);

  ats_pkg::kind_t           res_kind  [2];
  logic [ROW_BITS-1:0]      res_row   [2];
  logic [COL_BITS-1:0]      res_col   [2];
  logic [OFFSET_BITS-1:0]   res_off   [2];
  logic [LEN_BITS-1:0]      res_len   [2];
  logic [7:0]               res_stray [2];
  logic [1:0]               res_cnt;

  logic                     take;
  logic                     pop;
  logic [1:0]               push_n;

  ats_pkg::kind_t           q_kind  [QDEPTH];
  logic [ROW_BITS-1:0]      q_row   [QDEPTH];
  logic [COL_BITS-1:0]      q_col   [QDEPTH];
  logic [OFFSET_BITS-1:0]   q_off   [QDEPTH];
  logic [LEN_BITS-1:0]      q_len   [QDEPTH];
  logic [7:0]               q_stray [QDEPTH];
  logic                     q_last  [QDEPTH];
  logic [PTR_W-1:0]         wr_ptr, rd_ptr;
  logic [CNT_W-1:0]         count;

  ats_core #(
    .ROW_BITS    (ROW_BITS),
    .COL_BITS    (COL_BITS),
    .OFFSET_BITS (OFFSET_BITS),
    .LEN_BITS    (LEN_BITS)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .take      (take),
    .ch        (ch),
    .is_end    (is_end),
    .res_kind  (res_kind),
    .res_row   (res_row),
    .res_col   (res_col),
    .res_off   (res_off),
    .res_len   (res_len),
    .res_stray (res_stray),
    .res_cnt   (res_cnt)
  );

  // Handshake
  assign in_ready  = (count <= CNT_W'(QDEPTH - 2));
  assign take      = in_valid && in_ready;
  assign out_valid = (count != '0);
  assign pop       = out_valid && out_ready;
  assign push_n    = take ? res_cnt : 2'd0;

  // Result queue storage
  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      q_kind[wr_ptr]  <= res_kind[0];
      q_row[wr_ptr]   <= res_row[0];
      q_col[wr_ptr]   <= res_col[0];
      q_off[wr_ptr]   <= res_off[0];
      q_len[wr_ptr]   <= res_len[0];
      q_stray[wr_ptr] <= res_stray[0];
      q_last[wr_ptr]  <= (push_n == 2'd1);
    end
    if (push_n == 2'd2) begin
      q_kind[wr_ptr + PTR_W'(1)]  <= res_kind[1];
      q_row[wr_ptr + PTR_W'(1)]   <= res_row[1];
      q_col[wr_ptr + PTR_W'(1)]   <= res_col[1];
      q_off[wr_ptr + PTR_W'(1)]   <= res_off[1];
      q_len[wr_ptr + PTR_W'(1)]   <= res_len[1];
      q_stray[wr_ptr + PTR_W'(1)] <= res_stray[1];
      q_last[wr_ptr + PTR_W'(1)]  <= 1'b1;
    end
  end

  // Queue pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + PTR_W'(push_n);
      rd_ptr <= rd_ptr + PTR_W'(pop);
      count  <= count + CNT_W'(push_n) - CNT_W'(pop);
    end
  end

  // Head of queue drives the output
  assign kind         = q_kind[rd_ptr];
  assign start_row    = q_row[rd_ptr];
  assign start_col    = q_col[rd_ptr];
  assign start_offset = q_off[rd_ptr];
  assign length       = q_len[rd_ptr];
  assign stray_byte   = q_stray[rd_ptr];
  assign last         = q_last[rd_ptr];

`ifndef NO_ASSERTIONS
  // fill level tracks pushes and pops
  a_count_track: assert property (@(posedge clk) disable iff (rst)
    !rst |=> count == $past(count) + CNT_W'($past(push_n)) - CNT_W'($past(pop)))
    else $error("queue fill level out of step");

  // queue never overfills
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(QDEPTH))
    else $error("result queue overflow");

  // end of file is always the final result of its byte
  a_eof_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == ats_pkg::KIND_EOF |-> last)
    else $error("end of file not flagged last");

  // only an error carries a byte
  a_stray_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind != ats_pkg::KIND_STRAY |-> stray_byte == 8'd0)
    else $error("stray byte set on a non-error result");
`endif

endmodule

`default_nettype wire
